@@ hw/rtl/psadpcm_pkg.sv @@
// Shared types, constants and coefficient tables for the ADPCM block decoder.
package psadpcm_pkg;

	localparam int unsigned BlockSamples = 28;
	localparam int unsigned IdxW         = 5;
	localparam int unsigned CodesW       = 112;
	localparam int unsigned HistW        = 32;
	localparam int unsigned CoefW        = 10;
	localparam int unsigned ProdW        = HistW + CoefW;

	localparam logic [3:0] ShiftMax = 4'd12;
	localparam logic [3:0] FiltMax  = 4'd4;
	localparam logic [7:0] EndFlag  = 8'h01;

	localparam logic [IdxW-1:0] LastIdx = IdxW'(BlockSamples - 1);

	localparam logic signed [15:0] SatHi = 16'sh7fff;
	localparam logic signed [15:0] SatLo = -16'sh8000;

	// one queued block, already classified
	typedef struct packed {
		logic              channel;
		logic [3:0]        scale;
		logic [2:0]        filt;
		logic              bad;
		logic              eos;
		logic              clear;
		logic [CodesW-1:0] codes;
	} desc_t;

	// head of the block queue as the back end sees it
	typedef struct packed {
		logic  valid;
		desc_t desc;
	} head_t;

	// first prediction coefficient
	function automatic logic signed [CoefW-1:0] coef_a(input logic [2:0] filt);
		logic signed [CoefW-1:0] c;
		unique case (filt)
			3'd1:    c = 10'sd240;
			3'd2:    c = 10'sd460;
			3'd3:    c = 10'sd392;
			3'd4:    c = 10'sd488;
			default: c = '0;
		endcase
		return c;
	endfunction

	// second prediction coefficient
	function automatic logic signed [CoefW-1:0] coef_b(input logic [2:0] filt);
		logic signed [CoefW-1:0] c;
		unique case (filt)
			3'd2:    c = -10'sd208;
			3'd3:    c = -10'sd220;
			3'd4:    c = -10'sd240;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/psadpcm_if.sv @@
// Valid/ready channel interfaces for ADPCM blocks in and PCM samples out.
interface psadpcm_in_if;
	logic        valid;
	logic        ready;
	logic        channel;
	logic [7:0]  header_byte;
	logic [7:0]  flag_byte;
	logic [55:0] codes_low;
	logic [55:0] codes_high;
	logic        last_block;

	modport source (output valid, channel, header_byte, flag_byte, codes_low, codes_high,
		last_block, input ready);
	modport sink (input valid, channel, header_byte, flag_byte, codes_low, codes_high,
		last_block, output ready);
endinterface

interface psadpcm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               out_channel;
	logic [4:0]         sample_index;
	logic               block_done;
	logic               end_of_sound;
	logic               bad_header;

	modport source (output valid, sample, out_channel, sample_index, block_done,
		end_of_sound, bad_header, input ready);
	modport sink (input valid, sample, out_channel, sample_index, block_done,
		end_of_sound, bad_header, output ready);
endinterface

@@ hw/rtl/psadpcm_front.sv @@
// Front end: takes blocks, decodes the header and holds them in a two-entry queue.
module psadpcm_front (
	input  logic                     clk,
	input  logic                     arst_n,
	psadpcm_in_if.sink               blocks,
	output psadpcm_pkg::head_t       head,
	input  logic                     pop
);

	psadpcm_pkg::desc_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	psadpcm_pkg::desc_t cls;
	logic               push;

	// header classification: clamp bad shift / filter, precompute scale
	always_comb begin
		logic [3:0] shift;
		logic [3:0] filt;
		shift = blocks.header_byte[3:0];
		filt  = blocks.header_byte[7:4];
		cls.channel = blocks.channel;
		cls.bad     = (shift > psadpcm_pkg::ShiftMax) || (filt > psadpcm_pkg::FiltMax);
		cls.scale   = (shift > psadpcm_pkg::ShiftMax) ? 4'd0 : psadpcm_pkg::ShiftMax - shift;
		cls.filt    = (filt > psadpcm_pkg::FiltMax) ? 3'd0 : filt[2:0];
		cls.eos     = (blocks.flag_byte == psadpcm_pkg::EndFlag);
		cls.clear   = (blocks.flag_byte == psadpcm_pkg::EndFlag) || blocks.last_block;
		cls.codes   = {blocks.codes_high, blocks.codes_low};
	end

	assign blocks.ready = (count_q != 2'd2);
	assign push         = blocks.valid && blocks.ready;

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= cls;
	end

	assign head.valid = (count_q != 2'd0);
	assign head.desc  = entry_q[rd_ptr_q];

endmodule

@@ hw/rtl/psadpcm_back.sv @@
// Back end: prediction recurrence to output register, one sample per cycle unless stalled.
module psadpcm_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  psadpcm_pkg::head_t       head,
	output logic                     pop,
	psadpcm_out_if.source            samples
);

	logic signed [psadpcm_pkg::HistW-1:0] hist1_q [2];
	logic signed [psadpcm_pkg::HistW-1:0] hist2_q [2];
	logic [psadpcm_pkg::IdxW-1:0]         idx_q;
	logic                                 out_valid_q;
	logic signed [15:0]                   sample_q;
	logic                                 chan_q;
	logic [psadpcm_pkg::IdxW-1:0]         sidx_q;
	logic                                 done_q;
	logic                                 eos_q;
	logic                                 bad_q;

	logic                                 adv;
	logic                                 last;
	logic                                 ch;
	logic [3:0]                           nib;
	logic signed [psadpcm_pkg::HistW-1:0] code_sh;
	logic signed [psadpcm_pkg::HistW-1:0] p1;
	logic signed [psadpcm_pkg::HistW-1:0] p2;
	logic signed [psadpcm_pkg::ProdW-1:0] prod_a;
	logic signed [psadpcm_pkg::ProdW-1:0] prod_b;
	logic [psadpcm_pkg::HistW-1:0]        term_a;
	logic [psadpcm_pkg::HistW-1:0]        term_b;
	logic signed [psadpcm_pkg::HistW-1:0] v;
	logic signed [15:0]                   sat;

	assign adv  = head.valid && (!out_valid_q || samples.ready);
	assign last = (idx_q == psadpcm_pkg::LastIdx);
	assign pop  = adv && last;
	assign ch   = head.desc.channel;

	// code select and scaling
	assign nib     = head.desc.codes[{idx_q, 2'b00} +: 4];
	assign code_sh = psadpcm_pkg::HistW'(signed'(nib)) <<< head.desc.scale;

	// predictions: floor shift by 8 is the upper product bits, wrapped to 32
	assign p1     = hist1_q[ch];
	assign p2     = hist2_q[ch];
	assign prod_a = p1 * psadpcm_pkg::coef_a(head.desc.filt);
	assign prod_b = p2 * psadpcm_pkg::coef_b(head.desc.filt);
	assign term_a = prod_a[psadpcm_pkg::HistW+7:8];
	assign term_b = prod_b[psadpcm_pkg::HistW+7:8];
	assign v      = code_sh + signed'(term_a) + signed'(term_b);

	// saturate to 16 bits
	always_comb begin
		priority if (v > 32'sd32767)  sat = psadpcm_pkg::SatHi;
		else if (v < -32'sd32768)     sat = psadpcm_pkg::SatLo;
		else                          sat = v[15:0];
	end

	// sample counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				idx_q       <= last ? '0 : idx_q + 5'd1;
				out_valid_q <= 1'b1;
			end else if (samples.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// channel history; cleared after an end or last block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist1_q[0] <= '0;
			hist1_q[1] <= '0;
			hist2_q[0] <= '0;
			hist2_q[1] <= '0;
		end else if (adv) begin
			if (last && head.desc.clear) begin
				hist1_q[ch] <= '0;
				hist2_q[ch] <= '0;
			end else begin
				hist1_q[ch] <= v;
				hist2_q[ch] <= p1;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (adv) begin
			sample_q <= sat;
			chan_q   <= ch;
			sidx_q   <= idx_q;
			done_q   <= last;
			eos_q    <= last && head.desc.eos;
			bad_q    <= head.desc.bad;
		end
	end

	assign samples.valid        = out_valid_q;
	assign samples.sample       = sample_q;
	assign samples.out_channel  = chan_q;
	assign samples.sample_index = sidx_q;
	assign samples.block_done   = done_q;
	assign samples.end_of_sound = eos_q;
	assign samples.bad_header   = bad_q;

endmodule

@@ hw/rtl/ps_adpcm_block_decoder_unit.sv @@
// Top level of the ADPCM block decoder: block queue front end and sample back end.
//
//   port     dir  per transaction
//   blocks   in   one 16-byte ADPCM block with its channel and last-block mark
//   samples  out  one saturated PCM sample with channel, index and block status
//
// Each block yields 28 samples, one per cycle while the output is not stalled;
// the rate is set by the per-channel history multiply-add loop in the back end.
// The queue holds two blocks, so the next block is taken while one decodes.
// An accepted block is written into the queue; its first sample is then registered at the output.
// Reset empties the queue and output register and clears both channel histories.
// An output stall holds the sample register and stops the decode in place.
module ps_adpcm_block_decoder_unit (
	input  logic          clk,
	input  logic          arst_n,
	psadpcm_in_if.sink    blocks,
	psadpcm_out_if.source samples
);

	psadpcm_pkg::head_t head;
	logic               pop;

	psadpcm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.blocks (blocks),
		.head   (head),
		.pop    (pop)
	);

	psadpcm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.samples (samples)
	);

endmodule

@@ hw/rtl/psadpcm_checker.sv @@
// Port-level checks of the decoder's sample stream, bound to the top level.
module psadpcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] sample,
	input logic        out_channel,
	input logic [4:0]  sample_index,
	input logic        block_done,
	input logic        end_of_sound,
	input logic        bad_header
);

	logic out_acc;
	assign out_acc = out_valid && out_ready;

	// a stalled sample holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(sample_index))
		else $error("stalled sample changed");

	// samples of a block follow without gaps, same channel and header status
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !block_done |=> out_valid
			&& sample_index == $past(sample_index) + 5'd1
			&& out_channel == $past(out_channel)
			&& bad_header == $past(bad_header))
		else $error("sample sequence broken within block");

	// block end only on the last position
	a_done_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (block_done == (sample_index == 5'd27)))
		else $error("block_done at wrong index");

	// end of sound only on a block end
	a_eos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_sound |-> block_done)
		else $error("end_of_sound without block_done");

endmodule

bind ps_adpcm_block_decoder_unit psadpcm_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (samples.valid),
	.out_ready    (samples.ready),
	.sample       (samples.sample),
	.out_channel  (samples.out_channel),
	.sample_index (samples.sample_index),
	.block_done   (samples.block_done),
	.end_of_sound (samples.end_of_sound),
	.bad_header   (samples.bad_header)
);
